>>> sv/lfo_pkg.sv
// Shared types, codes and constants of the track LFO modulator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package lfo_pkg;

	localparam int DIVISOR_DEF = 1024;
	localparam int DIV_STEPS   = 5;

	localparam logic signed [31:0] WORD_MAX   = 32'sh007E_FFFF;
	localparam logic signed [31:0] GATE_LOAD  = 32'sh791D_0000;
	localparam logic signed [31:0] GATE_RELOAD = 32'sh78F0_0000;

	typedef enum logic [1:0] {
		CMD_STEP  = 2'd0,
		CMD_ACC   = 2'd1,
		CMD_APPLY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		CFG_PAGE      = 3'd0,
		CFG_DEST      = 3'd1,
		CFG_TRIG_MODE = 3'd2,
		CFG_WAVE      = 3'd3,
		CFG_MULT      = 3'd4,
		CFG_SPEED     = 3'd5,
		CFG_INTERLACE = 3'd6,
		CFG_DEPTH     = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_IDLE, OP_LATCH, OP_MUL1, OP_MUL2, OP_PREP, OP_DIV, OP_REM,
		OP_WAVE, OP_SCALE1, OP_SCALE2, OP_ACC, OP_APPLY
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_MUL2, ST_PREP, ST_DIV, ST_REM, ST_WAVE,
		ST_SCALE1, ST_SCALE2, ST_ACC, ST_APPLY, ST_DONE
	} state_t;

	typedef struct packed {
		op_t  op;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic div_last;
	} sts_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        elapsed;
		logic [15:0]        tick;
		logic               trig;
		logic               trig_pending;
		logic signed [31:0] target_word;
	} in_item_t;

	typedef struct packed {
		logic signed [24:0] wave_out;
		logic signed [31:0] level;
		logic               word_write;
		logic [5:0]         word_index;
		logic [22:0]        word_value;
	} out_item_t;

endpackage
`default_nettype wire

>>> sv/lfo_ctrl.sv
// Sequencer of the track LFO: steps the datapath through each command.
// Depends on lfo_pkg.
`default_nettype none
module lfo_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [1:0]    in_cmd,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	input  wire lfo_pkg::sts_t sts,
	output lfo_pkg::ctl_t      ctl
);
	import lfo_pkg::*;

	state_t state_q, state_n;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n      = state_q;
		ctl.op       = OP_IDLE;
		ctl.load_out = 1'b0;
		in_stall     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.op = OP_LATCH;
					case (cmd_t'(in_cmd))
						CMD_STEP:  state_n = ST_MUL1;
						CMD_ACC:   state_n = ST_ACC;
						CMD_APPLY: state_n = ST_APPLY;
						default:   state_n = ST_DONE;
					endcase
				end
			end
			ST_MUL1:   begin ctl.op = OP_MUL1;   state_n = ST_MUL2;   end
			ST_MUL2:   begin ctl.op = OP_MUL2;   state_n = ST_PREP;   end
			ST_PREP:   begin ctl.op = OP_PREP;   state_n = ST_DIV;    end
			ST_DIV: begin
				ctl.op = OP_DIV;
				if (sts.div_last) state_n = ST_REM;
			end
			ST_REM:    begin ctl.op = OP_REM;    state_n = ST_WAVE;   end
			ST_WAVE:   begin ctl.op = OP_WAVE;   state_n = ST_SCALE1; end
			ST_SCALE1: begin ctl.op = OP_SCALE1; state_n = ST_SCALE2; end
			ST_SCALE2: begin ctl.op = OP_SCALE2; state_n = ST_DONE;   end
			ST_ACC:    begin ctl.op = OP_ACC;    state_n = ST_DONE;   end
			ST_APPLY:  begin ctl.op = OP_APPLY;  state_n = ST_DONE;   end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					ctl.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> sv/lfo_dpath.sv
// Datapath of the track LFO: configuration, phase, divider, waveforms,
// scaling, gate timer, accumulator and output register. Depends on lfo_pkg.
`default_nettype none
module lfo_dpath #(
	parameter int DIVISOR = lfo_pkg::DIVISOR_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lfo_pkg::ctl_t     ctl,
	output lfo_pkg::sts_t          sts,
	input  wire lfo_pkg::in_item_t in_data,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	output lfo_pkg::out_item_t     out_data
);
	import lfo_pkg::*;

	localparam int DW  = (DIVISOR > 2) ? $clog2(DIVISOR) : 1;
	localparam int QDW = 32 + DW + 1;
	localparam logic [31:0]    HALF_C = 32'(DIVISOR / 2);
	// Reciprocal of the divisor scaled by 2^(32+DW); it fits in 33 bits for any divisor above one.
	localparam logic [32:0]    RCP_C  = 33'((64'd1 << (32 + DW)) / 64'(DIVISOR));
	localparam int CW = $clog2(DIV_STEPS);

	// Configuration registers.
	logic [3:0] page_q, wave_q;
	logic [2:0] dest_q, tmode_q, mult_q;
	logic [6:0] speed_q, ilace_q, depth_q;

	// Latched item.
	logic [1:0]         cmd_q;
	logic [15:0]        elapsed_q, tick_q;
	logic               trig_q, pend_q;
	logic signed [31:0] word_q;

	// LFO state.
	logic signed [31:0] phase_q, srem_q, wv_q, ra_q, rb_q, held_q;
	logic signed [31:0] gc_q, acc_q, delta_q, startl_q;
	logic [7:0]         rseg_q;
	logic               gate_q;
	logic [3:0]         lpage_q;
	logic [2:0]         ldest_q;

	// Working registers of a step.
	logic [28:0]        prod1_q;
	logic [31:0]        d2_q, sum_q, dvd_q;
	logic [48:0]        mlo_q, mhi_q;
	logic [31:0]        qe_q, dprod_q, quo_q;
	logic               neg_q, restart_q;
	logic [CW-1:0]      cnt_q;
	logic signed [31:0] inc_q, pa_q, pb_q;
	logic               wr_q;
	logic [5:0]         widx_q;
	logic [22:0]        wval_q;

	function automatic logic [2:0] mode_of(input logic [2:0] m);
		return (m > 3'd4) ? 3'd0 : m;
	endfunction

	function automatic logic [8:0] range_of(input logic [2:0] d);
		case (d)
			3'd0:    return 9'd2;
			3'd1:    return 9'd4;
			3'd2:    return 9'd14;
			3'd3:    return 9'd24;
			3'd4:    return 9'd48;
			3'd5:    return 9'd96;
			3'd6:    return 9'd192;
			default: return 9'd384;
		endcase
	endfunction

	function automatic logic signed [31:0] start_of(input logic [3:0] w);
		case (w)
			4'd3, 4'd4, 4'd6: return 32'sh0080_0000;
			4'd2, 4'd5, 4'd7: return -32'sh0080_0000;
			default:          return 32'sh0;
		endcase
	endfunction

	logic [2:0] mode;
	logic       retrig;
	assign mode   = mode_of(tmode_q);
	assign retrig = (mode != 3'd0) && (mode != 3'd2);

	// Numerator, and the quotient estimate from the two reciprocal half products.
	// The estimate is never above the true quotient and at most one below it.
	logic [31:0] sum_n, num_n, qe_n, dres;
	logic [64:0] rprod;
	always_comb begin
		sum_n = d2_q + srem_q;
		num_n = sum_n + HALF_C;
		rprod = {mhi_q, 16'd0} + 65'(mlo_q);
		qe_n  = 32'(rprod >> (32 + DW));
		dres  = dvd_q - dprod_q;
	end
	assign sts.div_last = (cnt_q == CW'(DIV_STEPS - 1));

	// Remainder, increment and phase update.
	logic signed [31:0] q_n, srem_n, inc_n, phase_n, padd;
	logic [QDW-1:0]     qd;
	logic               restart_n;
	always_comb begin
		q_n    = neg_q ? -$signed(quo_q) : $signed(quo_q);
		qd     = QDW'(q_n) * QDW'(DIVISOR);
		srem_n = $signed(sum_q - qd[31:0]);
		inc_n  = $signed(32'(q_n <<< (6 + mult_q)));
		padd   = phase_q + inc_n;
		if (trig_q && (mode == 3'd1 || mode == 3'd3 || mode == 3'd4)) begin
			phase_n   = 32'sh0;
			restart_n = 1'b1;
		end else begin
			phase_n   = padd;
			restart_n = 1'b0;
			if (mode == 3'd4 && padd > 32'sh0040_0000) begin
				phase_n = 32'sh0040_0000;
			end else if (padd > 32'sh007F_FFFF) begin
				if (mode == 3'd3) begin
					phase_n = 32'sh0080_0000;
				end else begin
					phase_n   = padd - 32'sh0080_0000;
					restart_n = 1'b1;
				end
			end
		end
	end

	// Waveform generator.
	logic signed [31:0] wv_n, ra_n, rb_n, p2, p4, rsum, emul_t;
	logic signed [48:0] emul;
	logic [7:0]         rseg_n, seg;
	logic               pedge;
	always_comb begin
		p2     = phase_q <<< 1;
		p4     = phase_q <<< 2;
		pedge  = (phase_q == 32'sh0080_0000) || (phase_q == 32'sh0040_0000);
		emul   = $signed(wv_q[31:10]) * $signed(inc_q[31:5]);
		emul_t = $signed(emul[31:0]);
		seg    = phase_q[27:20];
		rsum   = ra_q + rb_q;
		wv_n   = wv_q;
		ra_n   = ra_q;
		rb_n   = rb_q;
		rseg_n = rseg_q;
		case (wave_q)
			4'd0: begin
				if (phase_q <= 32'sh001F_FFFF)     wv_n = p4;
				else if (phase_q > 32'sh005F_FFFF) wv_n = p4 - 32'sh0200_0000;
				else                               wv_n = 32'sh0100_0000 - p4;
			end
			4'd1: begin
				if (phase_q <= 32'sh001F_FFFF)     wv_n = -p4;
				else if (phase_q > 32'sh005F_FFFF) wv_n = 32'sh0200_0000 - p4;
				else                               wv_n = p4 - 32'sh0100_0000;
			end
			4'd3: wv_n = 32'sh0080_0000 - p2;
			4'd4, 4'd5: begin
				if (pedge) wv_n = 32'sh0;
				else if ((phase_q <= 32'sh003F_FFFF) == (wave_q == 4'd4))
					wv_n = 32'sh0080_0000;
				else
					wv_n = -32'sh0080_0000;
			end
			4'd6, 4'd7: begin
				if (restart_q) wv_n = (wave_q == 4'd6) ? 32'sh0080_0000 : -32'sh0080_0000;
				else           wv_n = wv_q - (emul_t >>> 6);
			end
			4'd8: begin
				if (phase_q <= 32'sh003F_FFFF) wv_n = p2;
				else wv_n = (phase_q == 32'sh0040_0000) ? 32'sh0080_0000 : 32'sh0;
			end
			4'd9: begin
				if (phase_q <= 32'sh003F_FFFF) wv_n = -p2;
				else wv_n = (phase_q == 32'sh0040_0000) ? -32'sh0080_0000 : 32'sh0;
			end
			4'd10: begin
				if (pedge) begin
					wv_n = 32'sh0;
				end else if (restart_q || seg != rseg_q) begin
					rseg_n = seg;
					wv_n   = $signed({9'd0, rsum[22:0]}) - 32'sh0040_0000;
					rb_n   = ra_q;
					ra_n   = rsum;
				end
			end
			default: wv_n = p2 - 32'sh0080_0000;
		endcase
	end

	// Depth and range scaling.
	logic signed [31:0] src, sv, pa_n, pb_n, va, vb, sa, sb;
	logic signed [32:0] oa, ob;
	logic signed [41:0] ma, mb;
	logic signed [12:0] dsh;
	always_comb begin
		src = (mode == 3'd2) ? held_q : wv_q;
		sv  = start_of(wave_q);
		dsh = $signed({1'b0, depth_q, 5'd0});
		oa  = $signed(src[31:12]) * dsh;
		ob  = $signed(sv[31:12]) * dsh;
		if (page_q == 4'd0) begin
			pa_n = 32'($signed({1'b0, depth_q})) * 32'($signed(src[31:16]));
			pb_n = 32'($signed({1'b0, depth_q})) * 32'($signed(sv[31:16]));
		end else begin
			pa_n = $signed(oa[31:0]);
			pb_n = $signed(ob[31:0]);
		end
		sa = pa_q >>> 2;
		sb = pb_q >>> 2;
		ma = sa * $signed({1'b0, range_of(dest_q)});
		mb = sb * $signed({1'b0, range_of(dest_q)});
		if (page_q == 4'd0) begin
			va = $signed(ma[31:0]);
			vb = $signed(mb[31:0]);
		end else begin
			va = pa_q;
			vb = pb_q;
		end
	end

	// Gate timer decrement and apply.
	logic [32:0]        gmul;
	logic signed [31:0] aval;
	logic signed [32:0] tsum;
	logic [5:0]         widx_n;
	logic               wok;
	always_comb begin
		gmul = {ilace_q, 10'd0} * tick_q;
		aval = (pend_q && retrig) ? startl_q : acc_q;
		tsum = 33'(word_q) + 33'(aval);
		wok  = 1'b1;
		case (lpage_q)
			4'd0:    widx_n = 6'd30;
			4'd1:    widx_n = 6'd44 + 6'(ldest_q);
			4'd2:    widx_n = 6'(ldest_q);
			4'd3:    widx_n = 6'd8 + 6'(ldest_q);
			4'd4:    widx_n = 6'd16 + 6'(ldest_q);
			default: begin widx_n = 6'd0; wok = 1'b0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q   <= 4'd0;
			dest_q   <= 3'd4;
			tmode_q  <= 3'd0;
			wave_q   <= 4'd0;
			mult_q   <= 3'd0;
			speed_q  <= 7'd64;
			ilace_q  <= 7'd0;
			depth_q  <= 7'd0;
			phase_q  <= '0;
			srem_q   <= '0;
			wv_q     <= '0;
			ra_q     <= 32'sd1;
			rb_q     <= '0;
			rseg_q   <= '0;
			held_q   <= '0;
			gc_q     <= '0;
			gate_q   <= 1'b1;
			acc_q    <= '0;
			delta_q  <= '0;
			startl_q <= '0;
			lpage_q  <= '0;
			ldest_q  <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_PAGE:      page_q  <= cfg_data[3:0];
					CFG_DEST:      dest_q  <= cfg_data[2:0];
					CFG_TRIG_MODE: tmode_q <= cfg_data[2:0];
					CFG_WAVE:      wave_q  <= cfg_data[3:0];
					CFG_MULT:      mult_q  <= cfg_data[2:0];
					CFG_SPEED:     speed_q <= cfg_data[6:0];
					CFG_INTERLACE: ilace_q <= cfg_data[6:0];
					CFG_DEPTH:     depth_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			case (ctl.op)
				OP_PREP: cnt_q <= '0;
				OP_DIV:  cnt_q <= cnt_q + CW'(1);
				OP_REM: begin
					srem_q  <= srem_n;
					phase_q <= phase_n;
				end
				OP_WAVE: begin
					wv_q   <= wv_n;
					ra_q   <= ra_n;
					rb_q   <= rb_n;
					rseg_q <= rseg_n;
				end
				OP_SCALE1: begin
					if (trig_q) begin
						held_q <= wv_q;
						gc_q   <= GATE_LOAD;
						gate_q <= 1'b1;
					end
				end
				OP_SCALE2: begin
					delta_q <= (va - acc_q) >>> 2;
					if (retrig) startl_q <= vb;
					lpage_q <= page_q;
					ldest_q <= dest_q;
				end
				OP_ACC: begin
					if (ilace_q == 7'd0) begin
						gate_q <= 1'b1;
					end else if (gc_q < 0) begin
						gc_q   <= gc_q + GATE_RELOAD;
						gate_q <= !gate_q;
					end else begin
						gc_q <= gc_q - $signed(gmul[31:0]);
					end
					acc_q <= acc_q + delta_q;
				end
				OP_APPLY: begin
					if (gate_q) acc_q <= aval;
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the step and of the result.
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LATCH: begin
				cmd_q     <= in_data.command;
				elapsed_q <= in_data.elapsed;
				tick_q    <= in_data.tick;
				trig_q    <= in_data.trig;
				pend_q    <= in_data.trig_pending;
				word_q    <= in_data.target_word;
				wr_q      <= 1'b0;
				widx_q    <= '0;
				wval_q    <= '0;
			end
			OP_MUL1: prod1_q <= {speed_q, 6'd0} * tick_q;
			OP_MUL2: d2_q <= 32'(prod1_q) * 32'(elapsed_q);
			OP_PREP: begin
				sum_q  <= sum_n;
				neg_q  <= num_n[31];
				dvd_q  <= num_n[31] ? -num_n : num_n;
			end
			OP_DIV: begin
				// Low and high half products, estimate, back-multiply, one correction.
				case (cnt_q)
					CW'(0):  mlo_q   <= dvd_q[15:0] * RCP_C;
					CW'(1):  mhi_q   <= dvd_q[31:16] * RCP_C;
					CW'(2):  qe_q    <= qe_n;
					CW'(3):  dprod_q <= qe_q * 32'(DIVISOR);
					default: quo_q   <= (dres >= 32'(DIVISOR)) ? qe_q + 32'd1 : qe_q;
				endcase
			end
			OP_REM: begin
				inc_q     <= inc_n;
				restart_q <= restart_n;
			end
			OP_SCALE1: begin
				pa_q <= pa_n;
				pb_q <= pb_n;
			end
			OP_APPLY: begin
				if (gate_q && aval != 0 && wok && cmd_q == CMD_APPLY) begin
					wr_q   <= 1'b1;
					widx_q <= widx_n;
					if (tsum < 0)                wval_q <= '0;
					else if (tsum > 33'(WORD_MAX)) wval_q <= WORD_MAX[22:0];
					else                         wval_q <= tsum[22:0];
				end
			end
			default: ;
		endcase
		if (ctl.load_out) begin
			out_data.wave_out   <= wv_q[24:0];
			out_data.level      <= acc_q;
			out_data.word_write <= wr_q;
			out_data.word_index <= widx_q;
			out_data.word_value <= wval_q;
		end
	end

endmodule
`default_nettype wire

>>> sv/lfo_phase_wave_modulator.sv
// Track LFO modulator, top level: sequencer and datapath.
// A phase step runs the multiply, prepare, divide, remainder, wave and scale states;
// the divide state is a reciprocal-multiplication divider that splits the speed
// increment by DIVISOR. Accumulate and apply go straight to their own state.
// Throughput: one item at a time, the next accepted in the cycle after its result is loaded.
// Reset (arst_n low, asynchronous) restores all but the payload registers at once.
`default_nettype none
module lfo_phase_wave_modulator #(
	parameter int DIVISOR = lfo_pkg::DIVISOR_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire lfo_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output lfo_pkg::out_item_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);
	import lfo_pkg::*;

	// Command and status between the sequencer and the datapath.
	ctl_t ctl;
	sts_t sts;

	// Configuration beats are always taken; the user must make them arrive only when idle.
	assign cfg_ready = 1'b1;

	lfo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_cmd    (in_data.command),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// The datapath keeps the configuration, the whole LFO state and the result register.
	lfo_dpath #(
		.DIVISOR (DIVISOR)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data)
	);

	// Once a beat is taken the block is busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item still in work");

	// A result that writes no word carries zero index and value.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.word_write |->
			out_data.word_index == 6'd0 && out_data.word_value == 23'd0)
		else $error("word fields set without a write");

	// A written word stays inside the clamp range.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.word_write |-> out_data.word_value <= WORD_MAX[22:0])
		else $error("word value above the clamp limit");

endmodule
`default_nettype wire
